[rtl/core/skc_pkg.sv]
package skc_pkg;

    // k-mer geometry
    localparam int MAX_WORD_LEN = 8;
    localparam int KMER_W       = 2 * MAX_WORD_LEN;
    localparam int TABLE_DEPTH  = 1 << KMER_W;

    // field widths
    localparam int CODE_W = 4;
    localparam int OFF_W  = 32;
    localparam int CNT_W  = 32;
    localparam int LEN_W  = 4;
    localparam int RUN_W  = 4;
    localparam int CFG_W  = 32;
    localparam int CFG_A_W = 2;

    // stream widths, padded to whole bytes
    localparam int S_TDATA_W = ((CODE_W + OFF_W + 7) / 8) * 8;
    localparam int M_TDATA_W = ((KMER_W + OFF_W + CNT_W + 7) / 8) * 8;

    // remainder unit: DIV_BITS dividend bits per cycle
    localparam int DIV_BITS  = 4;
    localparam int DIV_STEPS = OFF_W / DIV_BITS;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS);

    localparam logic [CNT_W-1:0]  COUNT_MAX = '1;
    localparam logic [CODE_W-1:0] BASE_MAX  = CODE_W'(3);
    localparam logic [RUN_W-1:0]  RUN_MAX   = '1;

    // register indexes
    localparam logic [CFG_A_W-1:0] REG_WORD_LEN  = CFG_A_W'(0);
    localparam logic [CFG_A_W-1:0] REG_SKIP_DIST = CFG_A_W'(1);
    localparam logic [CFG_A_W-1:0] REG_MAX_HITS  = CFG_A_W'(2);

    // register reset values
    localparam logic [LEN_W-1:0] WORD_LEN_RST  = LEN_W'(MAX_WORD_LEN);
    localparam logic [LEN_W-1:0] SKIP_DIST_RST = LEN_W'(1);
    localparam logic [CNT_W-1:0] MAX_HITS_RST  = '1;

    typedef struct packed {
        logic              accept;
        logic              div_step;
        logic              rnd;
        logic              eval;
        logic              inc;
        logic              wr;
        logic              clr_en;
        logic [KMER_W-1:0] clr_addr;
    } skc_cmd_t;

    typedef struct packed {
        logic need_div;
        logic sample;
        logic out_free;
    } skc_stat_t;

    // low 2*k bits set
    function automatic logic [KMER_W-1:0] kmer_mask(input logic [LEN_W-1:0] k);
        logic [KMER_W-1:0] m;
        m = '0;
        for (int j = 0; j < KMER_W; j++)
        begin
            m[j] = (j < 2 * int'(k));
        end
        return m;
    endfunction

endpackage

[rtl/core/skc_ctrl.sv]
module skc_ctrl
    import skc_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      s_tvalid,
    output logic      s_tready,
    input  skc_stat_t stat,
    output skc_cmd_t  cmd
);

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_DIV,
        ST_RND,
        ST_EVAL,
        ST_INC,
        ST_WR
    } state_t;

    state_t                 state_reg;
    logic                   s_tready_reg;
    logic [KMER_W-1:0]      clr_cnt_reg;
    logic [DIV_CNT_W-1:0]   div_cnt_reg;
    logic                   accept;

    assign accept   = (state_reg == ST_IDLE) && s_tvalid && s_tready_reg;
    assign s_tready = s_tready_reg;

    always_comb
    begin
        cmd          = '0;
        cmd.accept   = accept;
        cmd.div_step = (state_reg == ST_DIV);
        cmd.rnd      = (state_reg == ST_RND);
        cmd.eval     = (state_reg == ST_EVAL);
        cmd.inc      = (state_reg == ST_INC);
        cmd.wr       = (state_reg == ST_WR) && stat.out_free;
        cmd.clr_en   = (state_reg == ST_CLEAR);
        cmd.clr_addr = clr_cnt_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_CLEAR;
            s_tready_reg <= 1'b0;
            clr_cnt_reg  <= '0;
            div_cnt_reg  <= '0;
        end
        else
        begin
            case (state_reg)
                ST_CLEAR:
                begin
                    clr_cnt_reg <= clr_cnt_reg + KMER_W'(1);
                    if (clr_cnt_reg == {KMER_W{1'b1}})
                    begin
                        state_reg    <= ST_IDLE;
                        s_tready_reg <= 1'b1;
                    end
                end
                ST_IDLE:
                begin
                    if (accept)
                    begin
                        s_tready_reg <= 1'b0;
                        div_cnt_reg  <= '0;
                        state_reg    <= stat.need_div ? ST_DIV : ST_EVAL;
                    end
                end
                ST_DIV:
                begin
                    div_cnt_reg <= div_cnt_reg + DIV_CNT_W'(1);
                    if (div_cnt_reg == DIV_CNT_W'(DIV_STEPS - 1))
                    begin
                        state_reg <= ST_RND;
                    end
                end
                ST_RND:
                begin
                    state_reg <= ST_EVAL;
                end
                ST_EVAL:
                begin
                    if (stat.sample)
                    begin
                        state_reg <= ST_INC;
                    end
                    else
                    begin
                        state_reg    <= ST_IDLE;
                        s_tready_reg <= 1'b1;
                    end
                end
                ST_INC:
                begin
                    state_reg <= ST_WR;
                end
                ST_WR:
                begin
                    if (stat.out_free)
                    begin
                        state_reg    <= ST_IDLE;
                        s_tready_reg <= 1'b1;
                    end
                end
                default:
                begin
                    state_reg    <= ST_CLEAR;
                    s_tready_reg <= 1'b0;
                end
            endcase
        end
    end

endmodule

[rtl/core/skc_datapath.sv]
module skc_datapath
    import skc_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [CFG_A_W-1:0]   cfg_addr,
    input  logic [CFG_W-1:0]     cfg_data,
    input  logic [S_TDATA_W-1:0] s_tdata,
    input  logic                 s_tuser,
    input  skc_cmd_t             cmd,
    output skc_stat_t            stat,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata,
    output logic                 m_tuser
);

    // configuration
    logic [LEN_W-1:0]  word_len_reg;
    logic [LEN_W-1:0]  skip_dist_reg;
    logic [CNT_W-1:0]  max_hits_reg;

    // sampler state
    logic [KMER_W-1:0] kmer_window_reg;
    logic [RUN_W-1:0]  valid_run_reg;
    logic [OFF_W-1:0]  next_start_reg;

    // current item
    logic [CODE_W-1:0] code_reg;
    logic [OFF_W-1:0]  off_reg;
    logic              start_reg;
    logic [OFF_W-1:0]  first_reg;

    // remainder unit
    logic [OFF_W-1:0]  div_reg;
    logic [LEN_W-1:0]  rem_reg;
    logic [LEN_W-1:0]  rem_next;
    logic [OFF_W-1:0]  rounded_reg;

    // count update
    logic [CNT_W-1:0]  count_mem [TABLE_DEPTH];
    logic [KMER_W-1:0] kc_reg;
    logic [CNT_W-1:0]  rd_data_reg;
    logic [CNT_W-1:0]  cnt_reg;

    // output register
    logic              out_valid_reg;
    logic [KMER_W-1:0] out_kmer_reg;
    logic [OFF_W-1:0]  out_start_reg;
    logic [CNT_W-1:0]  out_count_reg;
    logic              out_over_reg;

    logic [CODE_W-1:0] in_code;
    logic [OFF_W-1:0]  in_off;
    logic [LEN_W-1:0]  eff_k;
    logic [LEN_W-1:0]  eff_s;
    logic [LEN_W-1:0]  pad;
    logic              code_ok;
    logic [RUN_W-1:0]  run_new;
    logic [KMER_W-1:0] win_new;
    logic [OFF_W-1:0]  eff_start;
    logic              sample;
    logic [KMER_W-1:0] kc_new;

    assign in_code = s_tdata[CODE_W-1:0];
    assign in_off  = s_tdata[CODE_W +: OFF_W];

    always_comb
    begin
        if (word_len_reg == '0)
            eff_k = LEN_W'(1);
        else if (word_len_reg > LEN_W'(MAX_WORD_LEN))
            eff_k = LEN_W'(MAX_WORD_LEN);
        else
            eff_k = word_len_reg;
    end

    assign eff_s = (skip_dist_reg == '0) ? LEN_W'(1) : skip_dist_reg;

    assign stat.need_div = (in_code <= BASE_MAX) && !s_tuser && (valid_run_reg == '0);

    // restoring remainder, DIV_BITS bits per step; rem stays below eff_s
    always_comb
    begin
        logic [LEN_W:0]   t;
        logic [LEN_W-1:0] r;
        r = rem_reg;
        for (int i = 0; i < DIV_BITS; i++)
        begin
            t = {r, div_reg[OFF_W-1-i]};
            if (t >= {1'b0, eff_s})
                t = t - {1'b0, eff_s};
            r = t[LEN_W-1:0];
        end
        rem_next = r;
    end

    assign pad = (rem_reg == '0) ? '0 : (eff_s - rem_reg);

    // evaluation of the current base
    assign code_ok = (code_reg <= BASE_MAX);

    always_comb
    begin
        if (!code_ok)
            run_new = '0;
        else if (start_reg)
            run_new = RUN_W'(1);
        else if (valid_run_reg != RUN_MAX)
            run_new = valid_run_reg + RUN_W'(1);
        else
            run_new = valid_run_reg;

        if (!code_ok)
            win_new = kmer_window_reg;
        else if (start_reg)
            win_new = KMER_W'(code_reg[1:0]);
        else
            win_new = {kmer_window_reg[KMER_W-3:0], code_reg[1:0]};

        if (start_reg)
            eff_start = off_reg;
        else if (code_ok && (valid_run_reg == '0))
            eff_start = rounded_reg;
        else
            eff_start = next_start_reg;
    end

    assign sample = code_ok && (run_new >= eff_k) && (first_reg == eff_start);
    assign kc_new = win_new & kmer_mask(eff_k);

    assign stat.sample   = sample;
    assign stat.out_free = !out_valid_reg || m_tready;

    // control-side registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            word_len_reg    <= WORD_LEN_RST;
            skip_dist_reg   <= SKIP_DIST_RST;
            max_hits_reg    <= MAX_HITS_RST;
            kmer_window_reg <= '0;
            valid_run_reg   <= '0;
            next_start_reg  <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                if (cfg_addr == REG_WORD_LEN)
                    word_len_reg <= cfg_data[LEN_W-1:0];
                else if (cfg_addr == REG_SKIP_DIST)
                    skip_dist_reg <= cfg_data[LEN_W-1:0];
                else if (cfg_addr == REG_MAX_HITS)
                    max_hits_reg <= cfg_data[CNT_W-1:0];
            end

            if (cmd.eval)
            begin
                kmer_window_reg <= win_new;
                valid_run_reg   <= run_new;
                next_start_reg  <= sample ? (eff_start + OFF_W'(eff_s)) : eff_start;
            end

            if (cmd.wr)
                out_valid_reg <= 1'b1;
            else if (m_tready)
                out_valid_reg <= 1'b0;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            code_reg  <= in_code;
            off_reg   <= in_off;
            start_reg <= s_tuser;
            first_reg <= in_off - OFF_W'(eff_k - LEN_W'(1));
            div_reg   <= in_off;
            rem_reg   <= '0;
        end
        else if (cmd.div_step)
        begin
            div_reg <= div_reg << DIV_BITS;
            rem_reg <= rem_next;
        end

        if (cmd.rnd)
            rounded_reg <= off_reg + OFF_W'(pad);

        if (cmd.eval)
            kc_reg <= kc_new;

        if (cmd.inc)
            cnt_reg <= (rd_data_reg == COUNT_MAX) ? rd_data_reg : (rd_data_reg + CNT_W'(1));

        if (cmd.wr)
        begin
            out_kmer_reg  <= kc_reg;
            out_start_reg <= first_reg;
            out_count_reg <= cnt_reg;
            out_over_reg  <= (cnt_reg > max_hits_reg);
        end
    end

    // count table
    always_ff @(posedge clk)
    begin
        if (cmd.clr_en)
            count_mem[cmd.clr_addr] <= '0;
        else if (cmd.wr)
            count_mem[kc_reg] <= cnt_reg;

        if (cmd.eval)
            rd_data_reg <= count_mem[kc_new];
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = M_TDATA_W'({out_count_reg, out_start_reg, out_kmer_reg});
    assign m_tuser  = out_over_reg;

endmodule

[rtl/core/strided_kmer_counter_core.sv]
// Sequencing: a taken request goes to evaluation, through the remainder unit
//   (eight steps) and a rounding step first when the base needs realignment.
//   A sampled k-mer then takes a table read, increment and write-back, the last
//   waiting for a free output register; one request is in flight at a time.
// Reset: asynchronous, active low; afterwards the count table is cleared, all
//   65536 entries at one entry per cycle, and s_tready stays low until done.
module strided_kmer_counter_core
    import skc_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,

    // configuration writes: 0 word_len, 1 skip_dist, 2 max_hits
    input  logic                 cfg_we,
    input  logic [CFG_A_W-1:0]   cfg_addr,
    input  logic [CFG_W-1:0]     cfg_data,

    // base requests
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,  // [3:0] base_code, [35:4] ref_offset, zero pad
    input  logic                 s_tuser,  // seq_start

    // sampled k-mer results
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata,  // [15:0] kmer_code, [47:16] start_offset,
                                           // [79:48] hit_count
    output logic                 m_tuser   // over_limit
);

    skc_cmd_t  cmd;
    skc_stat_t stat;

    // Sequencer: table clear sweep, request intake, realign steps, count update.
    skc_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    // Window, sample tracking, remainder unit, count table and output register.
    // The output register lets a new request in while a result waits.
    skc_datapath u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_addr (cfg_addr),
        .cfg_data (cfg_data),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .cmd      (cmd),
        .stat     (stat),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

endmodule

[rtl/core/skc_checker.sv]
module skc_checker
    import skc_pkg::*;
(
    input logic                 clk,
    input logic                 rst_n,
    input logic                 cfg_we,
    input logic [CFG_A_W-1:0]   cfg_addr,
    input logic [CFG_W-1:0]     cfg_data,
    input logic                 s_tvalid,
    input logic                 s_tready,
    input logic [S_TDATA_W-1:0] s_tdata,
    input logic                 s_tuser,
    input logic                 m_tvalid,
    input logic                 m_tready,
    input logic [M_TDATA_W-1:0] m_tdata,
    input logic                 m_tuser
);

    // nothing offered or taken once reset has been seen at an edge
    a_reset_quiet: assert property (@(posedge clk) !rst_n |=> !s_tready && !m_tvalid)
        else $error("handshake active during reset");

    // one request in flight at a time
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("request taken while one is in flight");

    // a counted k-mer has a count of at least one
    a_count_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[KMER_W+OFF_W +: CNT_W] != '0)
        else $error("zero hit count on result");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result dropped while stalled");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

endmodule

bind strided_kmer_counter_core skc_checker u_skc_checker (.*);
